>>> rtl/core/mtsc_pkg.sv
// ----------------------------------------------------------------------------
// mtsc_pkg
// Shared types, widths and constants of the Markov transition scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsc_pkg;

    localparam int SYM_BITS       = 8;
    localparam int COUNT_BITS     = 32;
    localparam int NSYM           = 1 << SYM_BITS;
    localparam int PAIR_ADDR_BITS = 2 * SYM_BITS;
    localparam int CNT_DEPTH      = 1 << PAIR_ADDR_BITS;
    localparam int ALPHA_BITS     = SYM_BITS + 1;
    localparam int K_BITS         = 12;
    localparam int KV_BITS        = K_BITS + ALPHA_BITS;

    localparam logic [K_BITS-1:0] K_RESET = K_BITS'(256);

    localparam int LOG_IN_BITS   = COUNT_BITS + 9;
    localparam int MANT_BITS     = 32;
    localparam int NORM_BITS     = (LOG_IN_BITS > MANT_BITS) ? LOG_IN_BITS : MANT_BITS;
    localparam int EXP_BITS      = 6;
    localparam int FRAC_BITS     = 24;
    localparam int FRAC_IDX_BITS = 5;
    localparam int LOG_BITS      = EXP_BITS + FRAC_BITS;
    localparam int SQ_BITS       = 2 * MANT_BITS;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int PROD_BITS  = LOG_BITS + 32;
    localparam int TERM_SHIFT = 40;
    localparam int TERM_BITS  = PROD_BITS + 1 - TERM_SHIFT;
    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (TERM_SHIFT - 1);

    localparam int SUM_BITS     = 40;
    localparam int PAIR_BITS    = 16;
    localparam logic [PAIR_BITS-1:0] PAIR_MAX = '1;
    localparam int MEAN_BITS    = 24;
    localparam int DIV_BITS     = SUM_BITS + 2;
    localparam int DEN_BITS     = PAIR_BITS + 1;
    localparam int REM_BITS     = DEN_BITS + 1;
    localparam int DIV_CNT_BITS = 6;

    localparam logic [DIV_BITS-1:0] MEAN_POS_MAX = DIV_BITS'((1 << (MEAN_BITS - 1)) - 1);
    localparam logic [DIV_BITS-1:0] MEAN_NEG_MAG = DIV_BITS'(1 << (MEAN_BITS - 1));

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = 1;
    localparam int FIFO_CNT_BITS = 2;

    localparam logic MODE_TRAIN = 1'b0;
    localparam logic MODE_SCORE = 1'b1;

    typedef enum logic {
        CMD_START,
        CMD_PAIR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                mode;
        logic [SYM_BITS-1:0] from_sym;
        logic [SYM_BITS-1:0] to_sym;
        logic                last;
    } cmd_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_NORM,
        L_SQ,
        L_DONE
    } log_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_FETCH,
        B_EXEC,
        B_MARK,
        B_LOGN,
        B_LOGD,
        B_MUL,
        B_ACC,
        B_FIN,
        B_DIV,
        B_CLAMP,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/markov_transition_scorer.sv
// ----------------------------------------------------------------------------
// markov_transition_scorer
// First-order Markov transition trainer and scorer with add-k smoothing.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    mode, symbol, first_symbol, last_symbol
//   result    out_valid / out_ready  score_mean, pairs_scored
//   config    cfg_we                 cfg_wdata (smoothing_k)
//
// After reset a sweep clears the transition count, row total and seen
// memories, one entry per cycle, across all 65536 count entries; no request is
// taken until it ends.
// A training pair passes through fetch, execute and mark, for the memory
// read-modify-write and the two seen-flag updates.
// A scoring pair waits on the two serial logarithms (up to 40 normalizing
// steps and 24 squarings each).
// A closing scoring string adds the bit-serial mean division.
// A two-entry queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module markov_transition_scorer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [11:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [7:0]         symbol,
    input  wire logic               first_symbol,
    input  wire logic               last_symbol,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [23:0]      score_mean,
    output logic        [15:0]      pairs_scored
);

    logic           clear_done;
    logic           push;
    mtsc_pkg::cmd_t push_cmd;
    logic           queue_full;
    logic           pop;
    mtsc_pkg::cmd_t pop_cmd;
    logic           queue_empty;

    mtsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .symbol       (symbol),
        .first_symbol (first_symbol),
        .last_symbol  (last_symbol),
        .clear_done   (clear_done),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    mtsc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (queue_empty)
    );

    mtsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .clear_done   (clear_done),
        .queue_empty  (queue_empty),
        .queue_cmd    (pop_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .score_mean   (score_mean),
        .pairs_scored (pairs_scored)
    );

endmodule

`default_nettype wire

>>> rtl/core/mtsc_ram.sv
// ----------------------------------------------------------------------------
// mtsc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/mtsc_fifo.sv
// ----------------------------------------------------------------------------
// mtsc_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsc_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mtsc_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output mtsc_pkg::cmd_t     pop_cmd,
    output logic               empty
);

    mtsc_pkg::cmd_t                          entry_reg [mtsc_pkg::FIFO_DEPTH];
    logic [mtsc_pkg::FIFO_PTR_BITS-1:0]      wr_ptr_reg;
    logic [mtsc_pkg::FIFO_PTR_BITS-1:0]      rd_ptr_reg;
    logic [mtsc_pkg::FIFO_CNT_BITS-1:0]      count_reg;
    logic [mtsc_pkg::FIFO_CNT_BITS-1:0]      count_next;

    assign full    = (count_reg == mtsc_pkg::FIFO_CNT_BITS'(mtsc_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mtsc_front.sv
// ----------------------------------------------------------------------------
// mtsc_front
// Accepts symbols, tracks the open string and turns items into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [7:0]                    symbol,
    input  wire logic                          first_symbol,
    input  wire logic                          last_symbol,
    input  wire logic                          clear_done,
    input  wire logic                          queue_full,
    output logic                               push,
    output mtsc_pkg::cmd_t                     push_cmd
);

    logic                              open_reg;
    logic                              mode_reg;
    logic [mtsc_pkg::SYM_BITS-1:0]     prev_reg;
    logic [mtsc_pkg::SYM_BITS-1:0]     sym;
    logic                              accept;

    assign sym      = symbol[mtsc_pkg::SYM_BITS-1:0];
    assign in_ready = clear_done && !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (first_symbol || open_reg);

    always_comb
    begin
        push_cmd.kind     = first_symbol ? mtsc_pkg::CMD_START : mtsc_pkg::CMD_PAIR;
        push_cmd.mode     = first_symbol ? mode : mode_reg;
        push_cmd.from_sym = prev_reg;
        push_cmd.to_sym   = sym;
        push_cmd.last     = last_symbol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            mode_reg <= mtsc_pkg::MODE_TRAIN;
            prev_reg <= '0;
        end
        else if (push)
        begin
            open_reg <= !last_symbol;
            prev_reg <= sym;
            if (first_symbol)
            begin
                mode_reg <= mode;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mtsc_log2.sv
// ----------------------------------------------------------------------------
// mtsc_log2
// Iterative base-2 logarithm in Q24: a normalizing shift one bit per cycle,
// then one mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsc_log2 (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [mtsc_pkg::LOG_IN_BITS-1:0]   x,
    output logic                                    done,
    output logic      [mtsc_pkg::LOG_BITS-1:0]      result
);

    mtsc_pkg::log_state_t                  state_reg;
    mtsc_pkg::log_state_t                  state_next;
    logic [mtsc_pkg::NORM_BITS-1:0]        norm_reg;
    logic [mtsc_pkg::EXP_BITS-1:0]         exp_reg;
    logic [mtsc_pkg::MANT_BITS-1:0]        mant_reg;
    logic [mtsc_pkg::FRAC_BITS-1:0]        frac_reg;
    logic [mtsc_pkg::FRAC_IDX_BITS-1:0]    idx_reg;
    logic [mtsc_pkg::SQ_BITS-1:0]          sq;
    logic [mtsc_pkg::MANT_BITS:0]          sq_top;
    logic                                  take;

    assign take   = start && (state_reg == mtsc_pkg::L_IDLE || state_reg == mtsc_pkg::L_DONE);
    assign sq     = mtsc_pkg::SQ_BITS'(mant_reg) * mtsc_pkg::SQ_BITS'(mant_reg);
    assign sq_top = sq[mtsc_pkg::SQ_BITS-1:mtsc_pkg::MANT_BITS-1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtsc_pkg::L_IDLE:
            begin
                if (start)
                begin
                    state_next = mtsc_pkg::L_NORM;
                end
            end
            mtsc_pkg::L_NORM:
            begin
                if (norm_reg[mtsc_pkg::NORM_BITS-1])
                begin
                    state_next = mtsc_pkg::L_SQ;
                end
            end
            mtsc_pkg::L_SQ:
            begin
                if (idx_reg == '0)
                begin
                    state_next = mtsc_pkg::L_DONE;
                end
            end
            mtsc_pkg::L_DONE:
            begin
                state_next = start ? mtsc_pkg::L_NORM : mtsc_pkg::L_IDLE;
            end
            default:
            begin
                state_next = mtsc_pkg::L_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done   = (state_reg == mtsc_pkg::L_DONE);
        result = {exp_reg, frac_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtsc_pkg::L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            norm_reg <= (x == '0) ? mtsc_pkg::NORM_BITS'(1) : mtsc_pkg::NORM_BITS'(x);
            exp_reg  <= mtsc_pkg::EXP_BITS'(mtsc_pkg::NORM_BITS - 1);
        end
        else if (state_reg == mtsc_pkg::L_NORM)
        begin
            if (norm_reg[mtsc_pkg::NORM_BITS-1])
            begin
                mant_reg <= norm_reg[mtsc_pkg::NORM_BITS-1 -: mtsc_pkg::MANT_BITS];
                frac_reg <= '0;
                idx_reg  <= mtsc_pkg::FRAC_IDX_BITS'(mtsc_pkg::FRAC_BITS - 1);
            end
            else
            begin
                norm_reg <= norm_reg << 1;
                exp_reg  <= exp_reg - 1'b1;
            end
        end
        else if (state_reg == mtsc_pkg::L_SQ)
        begin
            if (sq_top[mtsc_pkg::MANT_BITS])
            begin
                mant_reg          <= sq_top[mtsc_pkg::MANT_BITS:1];
                frac_reg[idx_reg] <= 1'b1;
            end
            else
            begin
                mant_reg <= sq_top[mtsc_pkg::MANT_BITS-1:0];
            end
            idx_reg <= idx_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mtsc_back.sv
// ----------------------------------------------------------------------------
// mtsc_back
// Carries out commands: count updates, log terms, accumulation and the
// final mean division.
// ----------------------------------------------------------------------------
`default_nettype none

module mtsc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [11:0]                   cfg_wdata,
    output logic                               clear_done,
    input  wire logic                          queue_empty,
    input  wire mtsc_pkg::cmd_t                queue_cmd,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [23:0]                 score_mean,
    output logic        [15:0]                 pairs_scored
);

    mtsc_pkg::back_state_t                    state_reg;
    mtsc_pkg::back_state_t                    state_next;
    mtsc_pkg::cmd_t                           cmd_reg;

    logic [mtsc_pkg::K_BITS-1:0]              k_reg;
    logic [mtsc_pkg::PAIR_ADDR_BITS-1:0]      clr_addr_reg;
    logic [mtsc_pkg::ALPHA_BITS-1:0]          alpha_reg;
    logic [mtsc_pkg::LOG_IN_BITS-1:0]         d_reg;
    logic [mtsc_pkg::LOG_BITS-1:0]            ln_reg;
    logic [mtsc_pkg::LOG_BITS-1:0]            ld_reg;
    logic [mtsc_pkg::PROD_BITS-1:0]           prod_reg;
    logic                                     neg_reg;
    logic [mtsc_pkg::SUM_BITS-1:0]            sum_reg;
    logic [mtsc_pkg::PAIR_BITS-1:0]           pair_reg;
    logic [mtsc_pkg::DIV_BITS-1:0]            num_reg;
    logic [mtsc_pkg::DEN_BITS-1:0]            den_reg;
    logic [mtsc_pkg::REM_BITS-1:0]            rem_reg;
    logic [mtsc_pkg::DIV_CNT_BITS-1:0]        div_cnt_reg;
    logic [mtsc_pkg::MEAN_BITS-1:0]           res_mean_reg;
    logic [mtsc_pkg::PAIR_BITS-1:0]           res_pairs_reg;
    logic                                     out_valid_reg;
    logic [mtsc_pkg::MEAN_BITS-1:0]           out_mean_reg;
    logic [mtsc_pkg::PAIR_BITS-1:0]           out_pairs_reg;

    logic                                     cnt_we;
    logic [mtsc_pkg::PAIR_ADDR_BITS-1:0]      cnt_waddr;
    logic [mtsc_pkg::COUNT_BITS-1:0]          cnt_wdata;
    logic [mtsc_pkg::COUNT_BITS-1:0]          cnt_rdata;
    logic                                     row_we;
    logic [mtsc_pkg::SYM_BITS-1:0]            row_waddr;
    logic [mtsc_pkg::COUNT_BITS-1:0]          row_wdata;
    logic [mtsc_pkg::COUNT_BITS-1:0]          row_rdata;
    logic                                     seen_we;
    logic [mtsc_pkg::SYM_BITS-1:0]            seen_waddr;
    logic                                     seen_wdata;
    logic [mtsc_pkg::SYM_BITS-1:0]            seen_raddr;
    logic                                     seen_rdata;

    logic                                     log_start;
    logic [mtsc_pkg::LOG_IN_BITS-1:0]         log_x;
    logic                                     log_done;
    logic [mtsc_pkg::LOG_BITS-1:0]            log_result;

    logic [mtsc_pkg::COUNT_BITS-1:0]          cnt_inc;
    logic [mtsc_pkg::COUNT_BITS-1:0]          row_inc;
    logic [mtsc_pkg::KV_BITS-1:0]             kv;
    logic [mtsc_pkg::LOG_IN_BITS-1:0]         n_val;
    logic [mtsc_pkg::LOG_IN_BITS-1:0]         d_val;
    logic                                     seen_new;
    logic [mtsc_pkg::ALPHA_BITS-1:0]          alpha_add;
    logic                                     is_score;
    logic                                     can_score;
    logic                                     want_result;
    logic [mtsc_pkg::PROD_BITS:0]             prod_rnd;
    logic [mtsc_pkg::SUM_BITS-1:0]            term;
    logic                                     sum_neg;
    logic [mtsc_pkg::SUM_BITS-1:0]            sum_mag;
    logic [mtsc_pkg::REM_BITS-1:0]            rem_sh;
    logic                                     rem_ge;
    logic                                     out_free;
    logic [mtsc_pkg::LOG_BITS-1:0]            log_mag;

    mtsc_ram #(
        .WIDTH (mtsc_pkg::COUNT_BITS),
        .DEPTH (mtsc_pkg::CNT_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr ({cmd_reg.from_sym, cmd_reg.to_sym}),
        .rdata (cnt_rdata)
    );

    mtsc_ram #(
        .WIDTH (mtsc_pkg::COUNT_BITS),
        .DEPTH (mtsc_pkg::NSYM)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (cmd_reg.from_sym),
        .rdata (row_rdata)
    );

    mtsc_ram #(
        .WIDTH (1),
        .DEPTH (mtsc_pkg::NSYM)
    ) u_seen_ram (
        .clk   (clk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    mtsc_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_result)
    );

    assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
    assign row_inc = (row_rdata == '1) ? row_rdata : row_rdata + 1'b1;
    assign kv      = mtsc_pkg::KV_BITS'(k_reg) * mtsc_pkg::KV_BITS'(alpha_reg);
    assign n_val   = (mtsc_pkg::LOG_IN_BITS'(cnt_rdata) << 8) + mtsc_pkg::LOG_IN_BITS'(k_reg);
    assign d_val   = (mtsc_pkg::LOG_IN_BITS'(row_rdata) << 8) + mtsc_pkg::LOG_IN_BITS'(kv);

    // The seen flag of the source symbol is read during fetch, that of the
    // destination symbol during execute; a destination equal to the source
    // was already marked and is not counted again.
    assign seen_raddr = (state_reg == mtsc_pkg::B_EXEC) ? cmd_reg.to_sym : cmd_reg.from_sym;
    assign seen_new   = !seen_rdata
                     && (state_reg == mtsc_pkg::B_EXEC || cmd_reg.to_sym != cmd_reg.from_sym);
    assign alpha_add  = mtsc_pkg::ALPHA_BITS'(seen_new);

    assign is_score    = (cmd_reg.mode == mtsc_pkg::MODE_SCORE);
    assign can_score   = (pair_reg != mtsc_pkg::PAIR_MAX);
    assign want_result = cmd_reg.last && is_score;

    assign log_mag  = (ln_reg < ld_reg) ? ld_reg - ln_reg : ln_reg - ld_reg;
    assign prod_rnd = mtsc_pkg::PROD_BITS'(prod_reg) + mtsc_pkg::ROUND_HALF;
    assign term     = mtsc_pkg::SUM_BITS'(prod_rnd[mtsc_pkg::PROD_BITS:mtsc_pkg::TERM_SHIFT]);
    assign sum_neg  = sum_reg[mtsc_pkg::SUM_BITS-1];
    assign sum_mag  = sum_neg ? (~sum_reg + 1'b1) : sum_reg;

    assign rem_sh = {rem_reg[mtsc_pkg::REM_BITS-2:0], num_reg[mtsc_pkg::DIV_BITS-1]};
    assign rem_ge = (rem_sh >= mtsc_pkg::REM_BITS'(den_reg));

    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign score_mean   = out_mean_reg;
    assign pairs_scored = out_pairs_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtsc_pkg::B_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = mtsc_pkg::B_IDLE;
                end
            end
            mtsc_pkg::B_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = mtsc_pkg::B_FETCH;
                end
            end
            mtsc_pkg::B_FETCH:
            begin
                state_next = mtsc_pkg::B_EXEC;
            end
            mtsc_pkg::B_EXEC:
            begin
                if (cmd_reg.kind == mtsc_pkg::CMD_PAIR && is_score && can_score)
                begin
                    state_next = mtsc_pkg::B_LOGN;
                end
                else if (cmd_reg.kind == mtsc_pkg::CMD_PAIR && !is_score)
                begin
                    state_next = mtsc_pkg::B_MARK;
                end
                else
                begin
                    state_next = want_result ? mtsc_pkg::B_FIN : mtsc_pkg::B_IDLE;
                end
            end
            mtsc_pkg::B_MARK:
            begin
                state_next = mtsc_pkg::B_IDLE;
            end
            mtsc_pkg::B_LOGN:
            begin
                if (log_done)
                begin
                    state_next = mtsc_pkg::B_LOGD;
                end
            end
            mtsc_pkg::B_LOGD:
            begin
                if (log_done)
                begin
                    state_next = mtsc_pkg::B_MUL;
                end
            end
            mtsc_pkg::B_MUL:
            begin
                state_next = mtsc_pkg::B_ACC;
            end
            mtsc_pkg::B_ACC:
            begin
                state_next = want_result ? mtsc_pkg::B_FIN : mtsc_pkg::B_IDLE;
            end
            mtsc_pkg::B_FIN:
            begin
                if (pair_reg == '0 || alpha_reg == '0)
                begin
                    state_next = mtsc_pkg::B_EMIT;
                end
                else
                begin
                    state_next = mtsc_pkg::B_DIV;
                end
            end
            mtsc_pkg::B_DIV:
            begin
                if (div_cnt_reg == mtsc_pkg::DIV_CNT_BITS'(mtsc_pkg::DIV_BITS - 1))
                begin
                    state_next = mtsc_pkg::B_CLAMP;
                end
            end
            mtsc_pkg::B_CLAMP:
            begin
                state_next = mtsc_pkg::B_EMIT;
            end
            mtsc_pkg::B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mtsc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mtsc_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clear_done = (state_reg != mtsc_pkg::B_CLEAR);
        pop        = (state_reg == mtsc_pkg::B_IDLE) && !queue_empty;
        cnt_we     = 1'b0;
        cnt_waddr  = {cmd_reg.from_sym, cmd_reg.to_sym};
        cnt_wdata  = cnt_inc;
        row_we     = 1'b0;
        row_waddr  = cmd_reg.from_sym;
        row_wdata  = row_inc;
        seen_we    = 1'b0;
        seen_waddr = cmd_reg.from_sym;
        seen_wdata = 1'b1;
        log_start  = 1'b0;
        log_x      = d_reg;
        unique case (state_reg)
            mtsc_pkg::B_CLEAR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = clr_addr_reg;
                cnt_wdata  = '0;
                row_we     = 1'b1;
                row_waddr  = clr_addr_reg[mtsc_pkg::SYM_BITS-1:0];
                row_wdata  = '0;
                seen_we    = 1'b1;
                seen_waddr = clr_addr_reg[mtsc_pkg::SYM_BITS-1:0];
                seen_wdata = 1'b0;
            end
            mtsc_pkg::B_EXEC:
            begin
                if (cmd_reg.kind == mtsc_pkg::CMD_PAIR && !is_score)
                begin
                    cnt_we  = 1'b1;
                    row_we  = 1'b1;
                    seen_we = 1'b1;
                end
                if (cmd_reg.kind == mtsc_pkg::CMD_PAIR && is_score && can_score)
                begin
                    log_start = 1'b1;
                    log_x     = n_val;
                end
            end
            mtsc_pkg::B_MARK:
            begin
                seen_we    = 1'b1;
                seen_waddr = cmd_reg.to_sym;
            end
            mtsc_pkg::B_LOGN:
            begin
                log_start = log_done;
            end
            default:
            begin
                log_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtsc_pkg::B_CLEAR;
            clr_addr_reg  <= '0;
            k_reg         <= mtsc_pkg::K_RESET;
            alpha_reg     <= '0;
            sum_reg       <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                k_reg <= cfg_wdata;
            end
            if (state_reg == mtsc_pkg::B_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (state_reg == mtsc_pkg::B_EXEC)
            begin
                if (cmd_reg.kind == mtsc_pkg::CMD_START)
                begin
                    sum_reg  <= '0;
                    pair_reg <= '0;
                end
                else if (!is_score)
                begin
                    alpha_reg <= alpha_reg + alpha_add;
                end
            end
            if (state_reg == mtsc_pkg::B_MARK)
            begin
                alpha_reg <= alpha_reg + alpha_add;
            end
            if (state_reg == mtsc_pkg::B_ACC)
            begin
                sum_reg  <= neg_reg ? sum_reg - term : sum_reg + term;
                pair_reg <= pair_reg + 1'b1;
            end
            if (state_reg == mtsc_pkg::B_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= queue_cmd;
        end
        if (state_reg == mtsc_pkg::B_EXEC)
        begin
            d_reg <= d_val;
        end
        if (state_reg == mtsc_pkg::B_LOGN && log_done)
        begin
            ln_reg <= log_result;
        end
        if (state_reg == mtsc_pkg::B_LOGD && log_done)
        begin
            ld_reg <= log_result;
        end
        if (state_reg == mtsc_pkg::B_MUL)
        begin
            prod_reg <= mtsc_pkg::PROD_BITS'(log_mag) * mtsc_pkg::PROD_BITS'(mtsc_pkg::LN2_Q32);
            neg_reg  <= (ln_reg < ld_reg);
        end
        if (state_reg == mtsc_pkg::B_FIN)
        begin
            num_reg       <= (mtsc_pkg::DIV_BITS'(sum_mag) << 1)
                           + mtsc_pkg::DIV_BITS'(pair_reg);
            den_reg       <= {pair_reg, 1'b0};
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            res_mean_reg  <= '0;
            res_pairs_reg <= '0;
        end
        if (state_reg == mtsc_pkg::B_DIV)
        begin
            rem_reg     <= rem_ge ? rem_sh - mtsc_pkg::REM_BITS'(den_reg) : rem_sh;
            num_reg     <= {num_reg[mtsc_pkg::DIV_BITS-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (state_reg == mtsc_pkg::B_CLAMP)
        begin
            res_pairs_reg <= pair_reg;
            if (sum_neg)
            begin
                res_mean_reg <= (num_reg > mtsc_pkg::MEAN_NEG_MAG)
                              ? mtsc_pkg::MEAN_BITS'(mtsc_pkg::MEAN_NEG_MAG)
                              : ~num_reg[mtsc_pkg::MEAN_BITS-1:0] + 1'b1;
            end
            else
            begin
                res_mean_reg <= (num_reg > mtsc_pkg::MEAN_POS_MAX)
                              ? mtsc_pkg::MEAN_BITS'(mtsc_pkg::MEAN_POS_MAX)
                              : num_reg[mtsc_pkg::MEAN_BITS-1:0];
            end
        end
        if (state_reg == mtsc_pkg::B_EMIT && out_free)
        begin
            out_mean_reg  <= res_mean_reg;
            out_pairs_reg <= res_pairs_reg;
        end
    end

endmodule

`default_nettype wire
